// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// File: src/ipq_pkg.sv
package ipq_pkg;

	// fixed field widths of the channels
	localparam int OP_W       = 3;
	localparam int ID_W       = 8;
	localparam int PRI_W      = 32;
	localparam int RES_ID_W   = 6;
	localparam int OCC_W      = 7;
	localparam int CAP_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_AT_TOP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd1;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_CHANGE = 3'd1,
		OP_REMOVE = 3'd2,
		OP_GET    = 3'd3,
		OP_DELETE = 3'd4,
		OP_PEEK   = 3'd5
	} op_t;

endpackage

// File: src/ipq_req_if.sv
interface ipq_req_if;
	logic                         valid;
	logic                         ready;
	logic [ipq_pkg::OP_W-1:0]     operation;
	logic [ipq_pkg::ID_W-1:0]     entry_id;
	logic signed [ipq_pkg::PRI_W-1:0] priority_in;

	modport source(output valid, output operation, output entry_id, output priority_in,
		input ready);
	modport sink(input valid, input operation, input entry_id, input priority_in,
		output ready);
endinterface

// File: src/ipq_rsp_if.sv
interface ipq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             ok;
	logic [ipq_pkg::RES_ID_W-1:0]     result_id;
	logic signed [ipq_pkg::PRI_W-1:0] result_priority;
	logic [ipq_pkg::OCC_W-1:0]        occupancy;

	modport source(output valid, output ok, output result_id, output result_priority,
		output occupancy, input ready);
	modport sink(input valid, input ok, input result_id, input result_priority,
		input occupancy, output ready);
endinterface

// File: src/ipq_mem.sv
// Simple dual-port RAM, one write and one read port, registered read data.
module ipq_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: src/indexed_priority_queue.sv
// Indexed priority queue: at most one entry per id, each with a signed priority.
// req channel (valid/ready): operation, entry_id, priority_in. A transfer takes
// place when valid and ready are both high; ready is high while the block is idle.
// rsp channel (valid/ready): ok, result_id, result_priority, occupancy; one
// response per request, in request order.
// Configuration: cfg_write/cfg_index/cfg_data; the user must write it only
// while idle, the block does not enforce this. Index 0 min_at_top (reset 1),
// index 1 capacity_in_use (reset 64). Insert, change, remove and unknown ops
// pass EXEC and RESP after the request transfer; get priority of an active
// entry adds GET; delete top and peek top pass EXEC, one SCAN visit per entry
// below min(capacity_in_use, CAPACITY), DRAIN, FINAL and RESP, or EXEC and RESP
// at capacity zero. The scan reads one entry per cycle through the single read
// port of the priority RAM. The next request is taken the cycle after the
// response is loaded, so a new request waits until the last one is through.
// Reset clears all active marks, the occupancy and the control state; the
// priority RAM is not cleared (an entry is only read after being written).
// If the receiver stalls, the response waits in the output register; the next
// request is still taken and processed, and then waits for that register.
module indexed_priority_queue #(
	parameter int CAPACITY       = 64,
	parameter int PRIORITY_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ipq_req_if.sink                            req,
	ipq_rsp_if.source                          rsp,
	input  logic                               cfg_write,
	input  logic [ipq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ipq_pkg::CFG_DATA_W-1:0]     cfg_data
);

	`include "assert_macros.svh"

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// compare width covers both the 8-bit id and the entry count
	localparam int CMP_W = (CNT_W > ipq_pkg::ID_W) ? CNT_W : ipq_pkg::ID_W;
	localparam int PW    = PRIORITY_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_GET,
		S_SCAN,
		S_DRAIN,
		S_FINAL,
		S_RESP
	} state_t;

	state_t state_q;

	// configuration
	logic                         min_at_top_q;
	logic [ipq_pkg::CAP_W-1:0]    cap_q;

	// captured request
	ipq_pkg::op_t                 op_q;
	logic [ipq_pkg::ID_W-1:0]     id_q;
	logic [PW-1:0]                pri_q;

	// queue state
	logic [CAPACITY-1:0]          marks_q;
	logic [CNT_W-1:0]             count_q;

	// scan
	logic [IDX_W-1:0]             scan_idx_q;
	logic                         valid_s1;
	logic                         hit_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic                         found_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic signed [PW-1:0]         best_pri_q;

	// pending result
	logic                         res_ok_q;
	logic [IDX_W-1:0]             res_id_q;
	logic [PW-1:0]                res_pri_q;
	logic                         out_valid_q;

	// RAM port
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_raddr;
	logic [PW-1:0]                mem_rdata;

	logic [CMP_W-1:0]             cap_ext;
	logic [CMP_W-1:0]             cap_eff;
	logic [CMP_W-1:0]             id_ext;
	logic [IDX_W-1:0]             id_idx;
	logic                         id_valid;
	logic                         id_act;
	logic                         scan_last;
	logic                         better;
	logic                         del_commit;
	logic signed [63:0]           pin_ext;
	logic signed [63:0]           rpr_ext;
	logic [CMP_W-1:0]             res_id_ext;
	logic [CMP_W-1:0]             occ_ext;

	// capacity saturates at the physical depth
	assign cap_ext  = CMP_W'(cap_q);
	assign cap_eff  = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
	assign id_ext   = CMP_W'(id_q);
	assign id_idx   = id_ext[IDX_W-1:0];
	assign id_valid = id_ext < cap_eff;
	assign id_act   = id_valid && marks_q[id_idx];

	assign scan_last = (CMP_W'(scan_idx_q) == (cap_eff - CMP_W'(1)));

	// delete top retires the winner in this cycle
	assign del_commit = (state_q == S_FINAL) && (op_q == ipq_pkg::OP_DELETE) && found_q;

	// strict compare keeps the lowest id on ties (ascending scan)
	assign better = min_at_top_q ? ($signed(mem_rdata) < best_pri_q)
	                             : ($signed(mem_rdata) > best_pri_q);

	// narrow or widen the Q16.16 input to the stored width, sign preserved
	assign pin_ext = 64'($signed(req.priority_in));
	assign rpr_ext = 64'($signed(res_pri_q));
	assign res_id_ext = CMP_W'(res_id_q);
	assign occ_ext    = CMP_W'(count_q);

	assign mem_we = (state_q == S_EXEC) &&
		(((op_q == ipq_pkg::OP_INSERT) && id_valid && !id_act) ||
		 ((op_q == ipq_pkg::OP_CHANGE) && id_act));
	assign mem_raddr = (state_q == S_SCAN) ? scan_idx_q : id_idx;

	ipq_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (PW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (id_idx),
		.wdata (pri_q),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_at_top_q <= 1'b1;
			cap_q        <= ipq_pkg::CAP_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ipq_pkg::REG_MIN_AT_TOP: min_at_top_q <= cfg_data[0];
				ipq_pkg::REG_CAPACITY:   cap_q        <= cfg_data;
			endcase
		end
	end

	// control FSM with queue state, scan datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			marks_q     <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// scan compare, one entry per cycle behind the RAM read
			if (valid_s1 && hit_s1 && (!found_q || better)) begin
				found_q    <= 1'b1;
				best_idx_q <= idx_s1;
				best_pri_q <= $signed(mem_rdata);
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= ipq_pkg::op_t'(req.operation);
						id_q    <= req.entry_id;
						pri_q   <= pin_ext[PW-1:0];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_ok_q  <= 1'b0;
					res_id_q  <= '0;
					res_pri_q <= '0;
					state_q   <= S_RESP;
					unique case (op_q)
						ipq_pkg::OP_INSERT: begin
							if (id_valid && !id_act) begin
								marks_q[id_idx] <= 1'b1;
								count_q         <= count_q + CNT_W'(1);
								res_ok_q        <= 1'b1;
							end
						end
						ipq_pkg::OP_CHANGE: res_ok_q <= id_act;
						ipq_pkg::OP_REMOVE: begin
							if (id_act) begin
								marks_q[id_idx] <= 1'b0;
								if (count_q != '0) begin
									count_q <= count_q - CNT_W'(1);
								end
								res_ok_q <= 1'b1;
							end
						end
						ipq_pkg::OP_GET: begin
							// read issued this cycle at id_idx
							if (id_act) begin
								state_q <= S_GET;
							end
						end
						ipq_pkg::OP_DELETE, ipq_pkg::OP_PEEK: begin
							found_q <= 1'b0;
							if (cap_eff != '0) begin
								scan_idx_q <= '0;
								state_q    <= S_SCAN;
							end
						end
						default: ;
					endcase
				end
				S_GET: begin
					res_ok_q  <= 1'b1;
					res_pri_q <= mem_rdata;
					state_q   <= S_RESP;
				end
				S_SCAN: begin
					valid_s1 <= 1'b1;
					hit_s1   <= marks_q[scan_idx_q];
					idx_s1   <= scan_idx_q;
					if (scan_last) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: state_q <= S_FINAL;
				S_FINAL: begin
					if (found_q) begin
						res_ok_q  <= 1'b1;
						res_id_q  <= best_idx_q;
						res_pri_q <= best_pri_q;
						if (op_q == ipq_pkg::OP_DELETE) begin
							marks_q[best_idx_q] <= 1'b0;
							if (count_q != '0) begin
								count_q <= count_q - CNT_W'(1);
							end
						end
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q         <= 1'b1;
						rsp.ok              <= res_ok_q;
						rsp.result_id       <= res_id_ext[ipq_pkg::RES_ID_W-1:0];
						rsp.result_priority <= rpr_ext[ipq_pkg::PRI_W-1:0];
						rsp.occupancy       <= occ_ext[ipq_pkg::OCC_W-1:0];
						state_q             <= S_IDLE;
					end
				end
			endcase
		end
	end

	`ASSERT_CLK(a_count_matches_marks, count_q == CNT_W'($countones(marks_q)), "count vs marks")
	`ASSERT_NEVER(a_count_overflow, count_q > CNT_W'(CAPACITY), "occupancy above capacity")
	`ASSERT_CLK(a_delete_clears, del_commit |=> !marks_q[$past(best_idx_q)], "top still active")
	`ASSERT_CLK(a_scan_in_flight, valid_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN), "stray scan")

endmodule

// File: sim/ipq_reply_checker.sv
module ipq_reply_checker #(
	parameter int SLOTS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ipq_req_if                             req,
	ipq_rsp_if                             rsp,
	input  logic                           cfg_write,
	input  logic [ipq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipq_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                    mismatches,
	output int unsigned                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import ipq_pkg::*;

	typedef struct packed {
		logic                    ok;
		logic [RES_ID_W-1:0]     slot;
		logic signed [PRI_W-1:0] pri;
		logic [OCC_W-1:0]        occ;
	} reply_t;

	// shadow of the queue contents and registers
	logic signed [PRI_W-1:0] pri_mem [SLOTS];
	bit                      live [SLOTS];
	int unsigned             live_count;
	bit                      min_top;
	logic [CAP_W-1:0]        cap_reg;

	reply_t pending_replies [$];
	reply_t want;

	function automatic bit beats(input logic signed [PRI_W-1:0] a,
		input logic signed [PRI_W-1:0] b);
		return min_top ? (a < b) : (a > b);
	endfunction

	// Applies one request to the shadow state and returns the reply it earns.
	function automatic reply_t serve_request(input logic [OP_W-1:0] op,
		input logic [ID_W-1:0] id, input logic signed [PRI_W-1:0] pr);
		reply_t      r;
		int unsigned lim;
		int unsigned best;
		bit          known;
		bit          hit;
		bit          found;
		r     = '0;
		lim   = (cap_reg > SLOTS) ? SLOTS : cap_reg;
		known = id < lim;
		hit   = known && live[id[RES_ID_W-1:0]];
		found = 1'b0;
		best  = 0;
		case (op)
			OP_INSERT: if (known && !hit) begin
				pri_mem[id[RES_ID_W-1:0]] = pr;
				live[id[RES_ID_W-1:0]]    = 1'b1;
				live_count++;
				r.ok = 1'b1;
			end
			OP_CHANGE: if (hit) begin
				pri_mem[id[RES_ID_W-1:0]] = pr;
				r.ok = 1'b1;
			end
			OP_REMOVE: if (hit) begin
				live[id[RES_ID_W-1:0]] = 1'b0;
				if (live_count > 0)
					live_count--;
				r.ok = 1'b1;
			end
			OP_GET: if (hit) begin
				r.ok  = 1'b1;
				r.pri = pri_mem[id[RES_ID_W-1:0]];
			end
			OP_DELETE, OP_PEEK: begin
				// ascending scan, strict compare: lowest id wins ties
				for (int i = 0; i < lim; i++)
					if (live[i] && (!found || beats(pri_mem[i], pri_mem[best]))) begin
						best  = i;
						found = 1'b1;
					end
				if (found) begin
					r.ok   = 1'b1;
					r.slot = best[RES_ID_W-1:0];
					r.pri  = pri_mem[best];
					if (op == OP_DELETE) begin
						live[best] = 1'b0;
						if (live_count > 0)
							live_count--;
					end
				end
			end
			default: ;
		endcase
		r.occ = live_count[OCC_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] exp_val,
		input logic [31:0] got_val);
		if (got_val !== exp_val) begin
			mismatches++;
			$display("%0t ns: %s expected %h got %h", $time, what, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				live[i] = 1'b0;
			live_count = 0;
			min_top    = 1'b1;
			cap_reg    = CAP_RESET;
			pending_replies.delete();
			outstanding <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_MIN_AT_TOP)
					min_top = cfg_data[0];
				else if (cfg_index == REG_CAPACITY)
					cap_reg = cfg_data;
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_replies.size() == 0) begin
					mismatches++;
					$display("%0t ns: reply expected none got ok=%b id=%0d pri=%h occ=%0d",
						$time, rsp.ok, rsp.result_id, rsp.result_priority, rsp.occupancy);
				end else begin
					want = pending_replies.pop_front();
					check_field("ok", 32'(want.ok), 32'(rsp.ok));
					check_field("result_id", 32'(want.slot), 32'(rsp.result_id));
					check_field("result_priority", want.pri, rsp.result_priority);
					check_field("occupancy", 32'(want.occ), 32'(rsp.occupancy));
				end
			end
			if (req.valid && req.ready)
				pending_replies.push_back(serve_request(req.operation, req.entry_id,
					req.priority_in));
			outstanding <= pending_replies.size();
		end
	end

endmodule

// File: sim/indexed_priority_queue_tb.sv
module indexed_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ipq_pkg::*;

	localparam int SLOTS = 64;
	// longest scan with capacity 127 written plus setup, with margin
	localparam int SETTLE = 140;

	// codes outside the defined operations, the block must reject them
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	localparam logic signed [PRI_W-1:0] PRI_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [PRI_W-1:0] PRI_MIN   = 32'sh8000_0000;
	localparam logic signed [PRI_W-1:0] PRI_1P5   = 32'sh0001_8000; // 1.5 in Q16.16
	localparam logic signed [PRI_W-1:0] PRI_NEG1  = -32'sd1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           mismatches;
	int unsigned           outstanding;

	// sender burst bookkeeping
	int                    burst_left;
	// capacity as last written, used to aim ids at the valid range
	logic [CAP_W-1:0]      cap_now;
	// long receiver hold-offs: asked by the stimulus, served by the receiver
	int unsigned           holds_asked;
	int unsigned           holds_done;

	ipq_req_if req_ch ();
	ipq_rsp_if rsp_ch ();

	indexed_priority_queue #(
		.CAPACITY       (SLOTS),
		.PRIORITY_WIDTH (PRI_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ipq_reply_checker #(
		.SLOTS (SLOTS)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Receiver: switches among always ready, coin-flip stalls, rare stalls and a
	// fixed duty pattern, each for a random stretch. A requested hold-off keeps
	// ready low so the block backs up into its input.
	initial begin : receiver
		int mode;
		int mode_left;
		int stall_left;
		int tick;
		mode       = 0;
		mode_left  = 0;
		stall_left = 0;
		tick       = 0;
		holds_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (holds_asked != holds_done) begin
				holds_done++;
				stall_left = 400;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
					default: rsp_ch.ready <= ((tick % 7) < 4);
				endcase
			end
		end
	end

	// One request transfer. Valid stays high across a burst; between bursts the
	// sender usually drops valid for a random gap, sometimes goes straight on.
	task automatic send(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
		input logic signed [PRI_W-1:0] pr);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= op;
		req_ch.entry_id    <= id;
		req_ch.priority_in <= pr;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Drop valid and wait until every reply is back and the block is quiet.
	task automatic settle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		if (idx == REG_CAPACITY)
			cap_now = value;
	endtask

	// Random request, mostly aimed at valid ids so inserts land and scans have
	// something to find; some ids sit on or past the capacity boundary. Over
	// half the priorities come from a tiny pool so ties show up often.
	task automatic random_request();
		logic [OP_W-1:0]         op;
		logic [ID_W-1:0]         id;
		logic signed [PRI_W-1:0] pr;
		int                      lim;
		int                      k;
		lim = (cap_now > SLOTS) ? SLOTS : cap_now;
		k = $urandom_range(0, 99);
		if (k < 30)
			op = OP_INSERT;
		else if (k < 45)
			op = OP_CHANGE;
		else if (k < 55)
			op = OP_REMOVE;
		else if (k < 68)
			op = OP_GET;
		else if (k < 83)
			op = OP_DELETE;
		else if (k < 97)
			op = OP_PEEK;
		else
			op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
		k = $urandom_range(0, 19);
		if (lim == 0 || k == 0)
			id = ID_W'($urandom_range(0, 255));
		else if (k == 1)
			id = ID_W'(lim);
		else if (k == 2)
			id = ID_W'($urandom_range(lim, 255));
		else
			id = ID_W'($urandom_range(0, lim - 1));
		k = $urandom_range(0, 9);
		if (k < 4)
			pr = $urandom;
		else if (k < 7)
			pr = $urandom_range(0, 6) - 3;
		else if (k == 7)
			pr = PRI_MAX;
		else if (k == 8)
			pr = PRI_MIN;
		else
			pr = PRI_NEG1;
		send(op, id, pr);
	endtask

	// One configuration phase: wait for quiet, write both registers, then a
	// stream of random requests; optionally asks for a long receiver hold-off.
	task automatic run_phase(input bit min_top, input logic [CAP_W-1:0] cap,
		input int count, input bit long_hold);
		settle();
		write_reg(REG_MIN_AT_TOP, CFG_DATA_W'(min_top));
		write_reg(REG_CAPACITY, cap);
		for (int i = 0; i < count; i++) begin
			if (long_hold && i == count / 4)
				holds_asked++;
			random_request();
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_write   <= 1'b0;
		cfg_index   <= REG_MIN_AT_TOP;
		cfg_data    <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.operation   <= OP_INSERT;
		req_ch.entry_id    <= '0;
		req_ch.priority_in <= '0;
		burst_left  = 0;
		holds_asked = 0;
		cap_now     = CAP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass on reset settings (least priority on top, full capacity).
		send(OP_PEEK, 8'd0, '0);             // empty queue
		send(OP_DELETE, 8'd0, '0);           // empty queue
		send(OP_INSERT, 8'd0, PRI_MAX);
		send(OP_INSERT, 8'd63, PRI_MIN);
		send(OP_INSERT, 8'd63, '0);          // duplicate id
		send(OP_INSERT, 8'd64, '0);          // first id past capacity
		send(OP_INSERT, 8'd255, PRI_NEG1);   // top of the id field
		send(OP_GET, 8'd63, '0);
		send(OP_CHANGE, 8'd0, PRI_NEG1);
		send(OP_GET, 8'd0, '0);
		send(OP_CHANGE, 8'd5, PRI_1P5);      // absent entry
		send(OP_GET, 8'd5, '0);              // absent entry
		send(OP_REMOVE, 8'd5, '0);           // absent entry
		send(OP_INSERT, 8'd5, PRI_1P5);
		send(OP_INSERT, 8'd3, PRI_1P5);
		send(OP_CHANGE, 8'd63, PRI_1P5);     // three-way tie at 1.5
		send(OP_PEEK, 8'd0, '0);
		send(OP_REMOVE, 8'd0, '0);
		send(OP_PEEK, 8'd0, '0);             // tie goes to the lowest id
		send(OP_DELETE, 8'd0, '0);
		send(OP_DELETE, 8'd0, '0);
		send(OP_SPARE_A, 8'd63, PRI_MAX);    // unknown operation
		send(OP_SPARE_B, 8'd255, PRI_NEG1);  // unknown operation
		send(OP_GET, 8'd63, '0);
		send(OP_REMOVE, 8'd63, '0);

		// Capacity zero: every id is rejected and the scan finds nothing.
		run_phase(1'b1, 7'd0, 10, 1'b0);
		send(OP_INSERT, 8'd0, PRI_1P5);
		send(OP_PEEK, 8'd0, '0);
		send(OP_DELETE, 8'd0, '0);

		// Capacity above the array size saturates: id 63 usable, 64 not.
		run_phase(1'b0, 7'd127, 30, 1'b0);
		send(OP_INSERT, 8'd64, PRI_MAX);
		send(OP_REMOVE, 8'd63, '0);
		send(OP_INSERT, 8'd63, PRI_MAX);
		send(OP_PEEK, 8'd0, '0);

		// Random phases; shrinking capacity leaves high entries stranded but
		// still counted in occupancy.
		run_phase(1'b1, 7'd64, 150, 1'b0);
		run_phase(1'b0, 7'd16, 110, 1'b1);
		run_phase(1'b1, 7'd1, 80, 1'b0);
		run_phase(1'b0, 7'd64, 150, 1'b0);
		run_phase(1'b1, 7'd2, 80, 1'b0);
		run_phase(1'b0, 7'd40, 110, 1'b0);
		run_phase(1'b1, 7'd8, 100, 1'b1);
		run_phase(1'b1, 7'd64, 150, 1'b0);
		run_phase(1'b0, 7'd100, 100, 1'b0);

		settle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
